// File: hw/rtl/crt3_pkg.sv
// ----------------------------------------------------------------------------
// crt3_pkg: shared types and constants of the three-prime CRT recomposer
// Widths, register indexes, the micro-operation program of the Garner
// sequence, and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package crt3_pkg;

  // Field and storage widths.
  localparam int RES_W    = 62;
  localparam int LIMB_W   = 64;
  localparam int WIN_W    = 256;
  localparam int VAL_W    = 192;
  localparam int Q_W      = 124;
  localparam int W_W      = 128;
  localparam int OFF_W    = 7;
  localparam int CB_W     = 7;
  localparam int CNT_W    = 25;
  localparam int IDX_W    = 3;
  localparam int BIT_W    = 6;
  localparam int MAX_RES  = 5;
  localparam int LEFT_W   = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_P0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_P1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_P2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_INV01  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV012 = 3'd4;
  localparam logic [IDX_W-1:0] REG_CB     = 3'd5;
  localparam logic [IDX_W-1:0] REG_PL     = 3'd6;

  // Micro-operation kinds.
  typedef enum logic [2:0] {
    K_MM, K_WM, K_SUB12, K_ADD12, K_SUB1D
  } kind_e;

  // Multiplicand selects.
  typedef enum logic [2:0] {
    A_ONE, A_D, A_T1, A_P0, A_Q
  } asel_e;

  // Multiplier (bit-scanned operand) selects.
  typedef enum logic [3:0] {
    B_R0, B_R1, B_R2, B_A0, B_INV01, B_INV012, B_P0, B_P1, B_C1, B_C2
  } bsel_e;

  // Modulus selects.
  typedef enum logic [1:0] {
    P_ZERO, P_ONE, P_TWO
  } psel_e;

  // Result destinations.
  typedef enum logic [3:0] {
    D_A0, D_T1, D_T2, D_C1, D_C2, D_D, D_Q, D_W, D_V
  } dst_e;

  typedef struct packed {
    kind_e kind;
    asel_e asel;
    bsel_e bsel;
    psel_e psel;
    dst_e  dst;
  } uop_t;

  localparam int OP_W    = 4;
  localparam int NUM_OPS = 15;

  // Garner program: residue reductions, c1, c2, then the wide products.
  function automatic uop_t uop(input logic [OP_W-1:0] op);
    uop_t u;
    case (op)
      4'd0:    u = '{K_MM,    A_ONE, B_R0,     P_ZERO, D_A0};
      4'd1:    u = '{K_MM,    A_ONE, B_R1,     P_ONE,  D_T1};
      4'd2:    u = '{K_MM,    A_ONE, B_A0,     P_ONE,  D_T2};
      4'd3:    u = '{K_SUB12, A_ONE, B_R0,     P_ONE,  D_D};
      4'd4:    u = '{K_MM,    A_D,   B_INV01,  P_ONE,  D_C1};
      4'd5:    u = '{K_MM,    A_ONE, B_P0,     P_TWO,  D_T1};
      4'd6:    u = '{K_MM,    A_T1,  B_C1,     P_TWO,  D_T2};
      4'd7:    u = '{K_MM,    A_ONE, B_A0,     P_TWO,  D_T1};
      4'd8:    u = '{K_ADD12, A_ONE, B_R0,     P_TWO,  D_D};
      4'd9:    u = '{K_MM,    A_ONE, B_R2,     P_TWO,  D_T1};
      4'd10:   u = '{K_SUB1D, A_ONE, B_R0,     P_TWO,  D_D};
      4'd11:   u = '{K_MM,    A_D,   B_INV012, P_TWO,  D_C2};
      4'd12:   u = '{K_WM,    A_P0,  B_P1,     P_ZERO, D_Q};
      4'd13:   u = '{K_WM,    A_P0,  B_C1,     P_ZERO, D_W};
      4'd14:   u = '{K_WM,    A_Q,   B_C2,     P_ZERO, D_V};
      default: u = '{K_SUB12, A_ONE, B_R0,     P_ZERO, D_D};
    endcase
    return u;
  endfunction

  // Controller to datapath.
  typedef struct packed {
    logic             capture;
    logic             emit;
    logic             emit_last;
    logic             emit_err;
    logic             clear;
    logic             boff_sub;
    logic             boff_add;
    logic             init;
    logic             step;
    logic             fin;
    logic             exec;
    logic             wadd;
    logic [OP_W-1:0]  op;
    logic [BIT_W-1:0] idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             boff_high;
    logic             out_free;
    logic             item_last;
    logic             win_hi_nz;
    logic [CNT_W-1:0] rem;
  } sts_t;

endpackage

// File: hw/rtl/crt3_if.sv
// ----------------------------------------------------------------------------
// crt3 channel interfaces
// Residue input channel and limb output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crt3_in_if import crt3_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] residue_zero;
  logic [RES_W-1:0] residue_one;
  logic [RES_W-1:0] residue_two;
  logic             last_coeff;

  modport source(output valid, residue_zero, residue_one, residue_two, last_coeff,
                 input ready);
  modport sink(input valid, residue_zero, residue_one, residue_two, last_coeff,
               output ready);
endinterface

interface crt3_out_if import crt3_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] limb;
  logic              last_limb;
  logic              leftover_error;

  modport source(output valid, limb, last_limb, leftover_error, input ready);
  modport sink(input valid, limb, last_limb, leftover_error, output ready);
endinterface

// File: hw/rtl/crt3_datapath.sv
// ----------------------------------------------------------------------------
// crt3_datapath: registers and arithmetic of the recomposer
// Bit-serial modular multiplier, shift-add wide multiplier, carry window,
// configuration registers and the limb output register.
// ----------------------------------------------------------------------------
module crt3_datapath import crt3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [RES_W-1:0]  cfg_data_i,
  input  logic [RES_W-1:0]  residue_zero_i,
  input  logic [RES_W-1:0]  residue_one_i,
  input  logic [RES_W-1:0]  residue_two_i,
  input  logic              last_coeff_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LIMB_W-1:0] limb_o,
  output logic              last_limb_o,
  output logic              leftover_error_o
);

  logic [RES_W-1:0]  p0_q, p1_q, p2_q, inv01_q, inv012_q;
  logic [CB_W-1:0]   cb_q;
  logic [CNT_W-1:0]  pl_q;
  logic [RES_W-1:0]  r0_q, r1_q, r2_q;
  logic              last_q;
  logic [RES_W-1:0]  mm_q, mm_d;
  logic [RES_W-1:0]  a0_q, t1_q, t2_q, c1_q, c2_q, d_q, d_d;
  logic [Q_W-1:0]    q_q;
  logic [W_W-1:0]    w_q;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [WIN_W-1:0]  win_q, win_d;
  logic [OFF_W-1:0]  boff_q, boff_d;
  logic [CNT_W-1:0]  lemit_q, lemit_d;
  logic              out_valid_q;
  logic [LIMB_W-1:0] limb_q;
  logic              last_limb_q, err_q;

  uop_t              u;
  logic [RES_W-1:0]  ep0, ep1, ep2, pm, one_p, mm_a, b_val;
  logic [Q_W-1:0]    wm_a;
  logic              bit_v;
  logic [LIMB_W-1:0] s, s1, s2, p64, p2x;
  logic [RES_W:0]    x, y, ar;
  logic [CB_W-1:0]   b_eff;
  logic [WIN_W-1:0]  shifted;

  // Zero primes count as one.
  assign ep0 = (p0_q == '0) ? RES_W'(1) : p0_q;
  assign ep1 = (p1_q == '0) ? RES_W'(1) : p1_q;
  assign ep2 = (p2_q == '0) ? RES_W'(1) : p2_q;

  assign u = uop(cmd_i.op);

  // Operand selection.
  always_comb begin
    case (u.psel)
      P_ZERO:  pm = ep0;
      P_ONE:   pm = ep1;
      P_TWO:   pm = ep2;
      default: pm = ep0;
    endcase
    one_p = (pm == RES_W'(1)) ? '0 : RES_W'(1);
    case (u.asel)
      A_D:     mm_a = d_q;
      A_T1:    mm_a = t1_q;
      default: mm_a = one_p;
    endcase
    case (u.asel)
      A_Q:     wm_a = q_q;
      default: wm_a = {{(Q_W-RES_W){1'b0}}, ep0};
    endcase
    case (u.bsel)
      B_R0:     b_val = r0_q;
      B_R1:     b_val = r1_q;
      B_R2:     b_val = r2_q;
      B_A0:     b_val = a0_q;
      B_INV01:  b_val = inv01_q;
      B_INV012: b_val = inv012_q;
      B_P0:     b_val = ep0;
      B_P1:     b_val = ep1;
      B_C1:     b_val = c1_q;
      B_C2:     b_val = c2_q;
      default:  b_val = r0_q;
    endcase
  end

  assign bit_v = b_val[cmd_i.idx];

  // One step of the interleaved modular multiply: r = (2r + bit*a) mod p.
  always_comb begin
    p64   = {{(LIMB_W-RES_W){1'b0}}, pm};
    p2x   = {p64[LIMB_W-2:0], 1'b0};
    s     = {{(LIMB_W-RES_W-1){1'b0}}, mm_q, 1'b0}
          + (bit_v ? {{(LIMB_W-RES_W){1'b0}}, mm_a} : '0);
    s1    = s - p64;
    s2    = s - p2x;
    if (s >= p2x) begin
      mm_d = s2[RES_W-1:0];
    end else if (s >= p64) begin
      mm_d = s1[RES_W-1:0];
    end else begin
      mm_d = s[RES_W-1:0];
    end
  end

  // Combinational modular add and subtract on reduced operands.
  always_comb begin
    x = {1'b0, t1_q};
    y = (u.kind == K_SUB1D) ? {1'b0, d_q} : {1'b0, t2_q};
    ar = x + y;
    case (u.kind)
      K_ADD12: d_d = (ar >= {1'b0, pm}) ? RES_W'(ar - {1'b0, pm}) : ar[RES_W-1:0];
      default: d_d = (x >= y) ? RES_W'(x - y) : RES_W'(x + {1'b0, pm} - y);
    endcase
  end

  assign b_eff   = (cb_q > CB_W'(LIMB_W)) ? CB_W'(LIMB_W) : cb_q;
  assign shifted = {{(WIN_W-VAL_W){1'b0}}, acc_q} << boff_q[BIT_W-1:0];

  // Wide accumulator, carry window, offset and count.
  always_comb begin
    acc_d   = acc_q;
    win_d   = win_q;
    boff_d  = boff_q;
    lemit_d = lemit_q;
    if (cmd_i.init) begin
      acc_d = '0;
    end
    if (cmd_i.step && u.kind == K_WM) begin
      acc_d = {acc_q[VAL_W-2:0], 1'b0} + (bit_v ? {{(VAL_W-Q_W){1'b0}}, wm_a} : '0);
    end
    if (cmd_i.fin && u.dst == D_V) begin
      acc_d = acc_q + {{(VAL_W-W_W){1'b0}}, w_q};
    end
    if (cmd_i.wadd) begin
      win_d = win_q + shifted;
    end
    if (cmd_i.boff_sub) begin
      boff_d = boff_q - OFF_W'(LIMB_W);
    end
    if (cmd_i.boff_add) begin
      boff_d = boff_q + b_eff;
    end
    if (cmd_i.emit) begin
      win_d   = {{LIMB_W{1'b0}}, win_q[WIN_W-1:LIMB_W]};
      lemit_d = (lemit_q != '1) ? lemit_q + CNT_W'(1) : lemit_q;
    end
    if (cmd_i.clear) begin
      win_d   = '0;
      boff_d  = '0;
      lemit_d = '0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q     <= RES_W'(2);
      p1_q     <= RES_W'(2);
      p2_q     <= RES_W'(2);
      inv01_q  <= '0;
      inv012_q <= '0;
      cb_q     <= CB_W'(32);
      pl_q     <= CNT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_P0:     p0_q     <= cfg_data_i;
        REG_P1:     p1_q     <= cfg_data_i;
        REG_P2:     p2_q     <= cfg_data_i;
        REG_INV01:  inv01_q  <= cfg_data_i;
        REG_INV012: inv012_q <= cfg_data_i;
        REG_CB:     cb_q     <= cfg_data_i[CB_W-1:0];
        REG_PL:     pl_q     <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Window state and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      boff_q      <= '0;
      lemit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      boff_q  <= boff_d;
      lemit_q <= lemit_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r0_q   <= residue_zero_i;
      r1_q   <= residue_one_i;
      r2_q   <= residue_two_i;
      last_q <= last_coeff_i;
    end
    if (cmd_i.init) begin
      mm_q <= '0;
    end else if (cmd_i.step && u.kind == K_MM) begin
      mm_q <= mm_d;
    end
    acc_q <= acc_d;
    if (cmd_i.exec) begin
      d_q <= d_d;
    end
    if (cmd_i.fin) begin
      case (u.dst)
        D_A0:    a0_q <= mm_q;
        D_T1:    t1_q <= mm_q;
        D_T2:    t2_q <= mm_q;
        D_C1:    c1_q <= mm_q;
        D_C2:    c2_q <= mm_q;
        D_Q:     q_q  <= acc_q[Q_W-1:0];
        D_W:     w_q  <= acc_q[W_W-1:0] + {{(W_W-RES_W){1'b0}}, a0_q};
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      limb_q      <= win_q[LIMB_W-1:0];
      last_limb_q <= cmd_i.emit_last;
      err_q       <= cmd_i.emit_err;
    end
  end

  // Status back to the controller.
  assign sts_o.boff_high = boff_q >= OFF_W'(LIMB_W);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.item_last = last_q;
  assign sts_o.win_hi_nz = win_q[WIN_W-1:LIMB_W] != '0;
  assign sts_o.rem       = (pl_q > lemit_q) ? pl_q - lemit_q : '0;

  assign out_valid_o      = out_valid_q;
  assign limb_o           = limb_q;
  assign last_limb_o      = last_limb_q;
  assign leftover_error_o = err_q;

endmodule

// File: hw/rtl/crt3_controller.sv
// ----------------------------------------------------------------------------
// crt3_controller: sequencer of the recomposer
// Checks the offset and emits a due limb, walks the Garner program one
// micro-operation at a time, adds into the window, and drains on the last item.
// ----------------------------------------------------------------------------
module crt3_controller import crt3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_WADD  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [BIT_W-1:0]  cnt_q, cnt_d;
  logic              npre_q, npre_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic              err_q, err_d;
  logic [LEFT_W-1:0] cap;
  logic              op_last;
  uop_t              u;

  assign u       = uop(op_q);
  assign op_last = op_q == OP_W'(NUM_OPS - 1);
  assign cap     = npre_q ? LEFT_W'(MAX_RES - 1) : LEFT_W'(MAX_RES);

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    npre_d  = npre_q;
    left_d  = left_q;
    err_d   = err_q;
    cmd_o     = '0;
    cmd_o.op  = op_q;
    cmd_o.idx = BIT_W'(RES_W - 1) - cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          npre_d  = 1'b0;
          state_d = S_PRE;
        end
      end
      S_PRE: begin
        if (!sts_i.boff_high) begin
          op_d    = '0;
          state_d = S_INIT;
        end else if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.boff_sub = 1'b1;
          npre_d = 1'b1;
        end
      end
      S_INIT: begin
        if (u.kind == K_MM || u.kind == K_WM) begin
          cmd_o.init = 1'b1;
          cnt_d   = '0;
          state_d = S_ITER;
        end else begin
          cmd_o.exec = 1'b1;
          op_d    = op_q + OP_W'(1);
          state_d = op_last ? S_WADD : S_INIT;
        end
      end
      S_ITER: begin
        cmd_o.step = 1'b1;
        if (cnt_q == BIT_W'(RES_W - 1)) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + BIT_W'(1);
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        op_d    = op_q + OP_W'(1);
        state_d = op_last ? S_WADD : S_INIT;
      end
      S_WADD: begin
        cmd_o.wadd = 1'b1;
        if (!sts_i.item_last) begin
          cmd_o.boff_add = 1'b1;
          state_d = S_IDLE;
        end else begin
          // Drain length is clamped to at least one and to the free slots.
          if (sts_i.rem == '0) begin
            left_d = LEFT_W'(1);
            err_d  = 1'b1;
          end else if (sts_i.rem > CNT_W'(cap)) begin
            left_d = cap;
            err_d  = 1'b1;
          end else begin
            left_d = sts_i.rem[LEFT_W-1:0];
            err_d  = 1'b0;
          end
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (left_q == LEFT_W'(1)) begin
            cmd_o.emit_last = 1'b1;
            cmd_o.emit_err  = err_q || sts_i.win_hi_nz;
            cmd_o.clear     = 1'b1;
            state_d = S_IDLE;
          end else begin
            left_d = left_q - LEFT_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      cnt_q   <= '0;
      npre_q  <= 1'b0;
      left_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      npre_q  <= npre_d;
      left_q  <= left_d;
      err_q   <= err_d;
    end
  end

  // A limb is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.emit |-> sts_i.out_free)
    else $error("limb emitted while output register busy");

  // An accepted coefficient blocks the input until it is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // The drain never schedules more limbs than one step may produce.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN |-> left_q != '0 && left_q <= LEFT_W'(MAX_RES))
    else $error("drain count out of range");

endmodule

// File: hw/rtl/crt3_carry_recompose_top.sv
// ----------------------------------------------------------------------------
// crt3_carry_recompose_top: three-prime CRT carry recomposer
// Rebuilds each coefficient from three residues and emits 64-bit limbs.
// ----------------------------------------------------------------------------
// Nine 62-step bit-serial modular multiplies and three 62-step shift-add wide
// multiplies run one after the other, each with a setup and a store state.
// Three modular adds and subtracts run between them; capture and the offset
// check come before the sequence and the window add after it. One limb may
// leave before the Garner sequence; the final drain emits one limb per cycle
// while the output register can take it. One coefficient is in work at a
// time. Reset restores the register defaults and clears the window.
module crt3_carry_recompose_top import crt3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [RES_W-1:0] cfg_data_i,
  crt3_in_if.sink          in_i,
  crt3_out_if.source       out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  crt3_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  crt3_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .residue_zero_i   (in_i.residue_zero),
    .residue_one_i    (in_i.residue_one),
    .residue_two_i    (in_i.residue_two),
    .last_coeff_i     (in_i.last_coeff),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .limb_o           (out_o.limb),
    .last_limb_o      (out_o.last_limb),
    .leftover_error_o (out_o.leftover_error)
  );

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: regression for the three-prime CRT carry recomposer
// Sends residue triples through the input channel and checks every 64-bit
// limb against a predictor that rebuilds each coefficient by Garner's method
// and keeps its own carry window, typed rows excepted. A directed table goes
// first, then phases of random products, register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crt3_pkg::*;

  localparam int               WATCHDOG_LIMIT = 20000;
  localparam int               SETTLE_CYCLES  = 2500;
  localparam int               RANDOM_PHASES  = 8;
  localparam int               PHASE_ITEMS    = 40;
  localparam logic [RES_W-1:0] RES_ONES       = {RES_W{1'b1}};

  // Expected limb transaction.
  typedef struct {
    logic [LIMB_W-1:0] limb;
    logic              last_limb;
    logic              leftover_error;
  } limb_t;

  // Row of the directed stimulus table.
  typedef struct {
    bit                is_cfg;
    logic [IDX_W-1:0]  idx;
    logic [RES_W-1:0]  data;
    logic [RES_W-1:0]  r0;
    logic [RES_W-1:0]  r1;
    logic [RES_W-1:0]  r2;
    bit                last;
    bit                typed;
    logic [LIMB_W-1:0] low_limb;
    logic [LIMB_W-1:0] last_limb;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [RES_W-1:0] cfg_data_i;

  crt3_in_if  in_if ();
  crt3_out_if out_if ();

  crt3_carry_recompose_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor copy of the registers and the recomposition state.
  logic [RES_W-1:0] prime0_q, prime1_q, prime2_q, inv01_q, inv012_q;
  logic [CB_W-1:0]  spacing_q;
  logic [CNT_W-1:0] limb_target_q;
  logic [WIN_W-1:0] window_q;
  logic [OFF_W-1:0] offset_q;
  logic [CNT_W-1:0] emitted_q;

  limb_t limb_expect_q[$];
  row_t  directed_rows[$];

  int errors;
  int coeffs_sent;
  int limbs_seen;
  int products_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  // Clock: 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  // Modular helpers on 64-bit operands, moduli below 2^62.
  function automatic logic [63:0] eff_prime(input logic [RES_W-1:0] p);
    return (p == '0) ? 64'd1 : 64'(p);
  endfunction

  function automatic logic [63:0] mul_mod(input logic [63:0] a, b, p);
    logic [127:0] prod;
    prod = 128'(a % p) * 128'(b % p);
    return 64'(prod % 128'(p));
  endfunction

  function automatic logic [63:0] sub_mod(input logic [63:0] a, b, p);
    logic [63:0] x, y;
    x = a % p;
    y = b % p;
    return (x >= y) ? x - y : x + (p - y);
  endfunction

  // Garner reconstruction of one coefficient below p0*p1*p2.
  function automatic logic [VAL_W-1:0] crt_value(input logic [RES_W-1:0] r0, r1, r2);
    logic [63:0]  p0, p1, p2, a0, c1, xm, c2;
    logic [127:0] x;
    p0 = eff_prime(prime0_q);
    p1 = eff_prime(prime1_q);
    p2 = eff_prime(prime2_q);
    a0 = 64'(r0) % p0;
    c1 = mul_mod(sub_mod(64'(r1), a0, p1), 64'(inv01_q), p1);
    x  = 128'(p0) * 128'(c1) + 128'(a0);
    xm = ((a0 % p2) + mul_mod(p0, c1, p2)) % p2;
    c2 = mul_mod(sub_mod(64'(r2), xm, p2), 64'(inv012_q), p2);
    return VAL_W'(x) + VAL_W'(p0) * VAL_W'(p1) * VAL_W'(c2);
  endfunction

  // Shifts the low limb out of the window.
  function automatic logic [LIMB_W-1:0] take_limb();
    logic [LIMB_W-1:0] limb;
    limb     = window_q[LIMB_W-1:0];
    window_q = window_q >> LIMB_W;
    if (emitted_q != {CNT_W{1'b1}}) begin
      emitted_q++;
    end
    return limb;
  endfunction

  function automatic void push_limb(input logic [LIMB_W-1:0] limb, input bit last,
                                    input bit err, input bit record);
    limb_t e;
    e.limb           = limb;
    e.last_limb      = last;
    e.leftover_error = err;
    if (record) begin
      limb_expect_q.push_back(e);
    end
  endfunction

  // Advances the predictor by one accepted coefficient.
  function automatic void predict_coeff(input logic [RES_W-1:0] r0, r1, r2,
                                        input bit last, input bit record);
    int               n;
    int               want;
    int               cap;
    bit               err;
    logic [CB_W-1:0]  spacing;
    logic [CNT_W-1:0] remaining;
    logic [LIMB_W-1:0] limb;
    n       = 0;
    err     = 1'b0;
    spacing = (spacing_q > 7'd64) ? 7'd64 : spacing_q;
    while (offset_q >= OFF_W'(LIMB_W) && n < MAX_RES) begin
      push_limb(take_limb(), 1'b0, 1'b0, record);
      n++;
      offset_q -= OFF_W'(LIMB_W);
    end
    window_q = window_q + ({64'd0, crt_value(r0, r1, r2)} << offset_q[5:0]);
    if (!last) begin
      offset_q = offset_q + spacing;
      return;
    end
    remaining = (limb_target_q > emitted_q) ? limb_target_q - emitted_q : '0;
    cap       = MAX_RES - n;
    want      = int'(remaining);
    if (want == 0) begin
      want = 1;
      err  = 1'b1;
    end
    if (want > cap) begin
      want = cap;
      err  = 1'b1;
    end
    for (int i = 0; i + 1 < want; i++) begin
      push_limb(take_limb(), 1'b0, 1'b0, record);
    end
    limb = take_limb();
    if (window_q != '0) begin
      err = 1'b1;
    end
    push_limb(limb, 1'b1, err, record);
    window_q  = '0;
    offset_q  = '0;
    emitted_q = '0;
  endfunction

  // Register write: one cycle of write enable, predictor updated alongside.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RES_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_P0:     prime0_q      = data;
      REG_P1:     prime1_q      = data;
      REG_P2:     prime2_q      = data;
      REG_INV01:  inv01_q       = data;
      REG_INV012: inv012_q      = data;
      REG_CB:     spacing_q     = data[CB_W-1:0];
      REG_PL:     limb_target_q = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Waits until every expected limb is out and the block has gone quiet.
  task automatic wait_idle();
    while (limb_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sends one coefficient; called and returning at a falling edge.
  task automatic send_coeff(input logic [RES_W-1:0] r0, r1, r2, input bit last,
                            input bit record);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.residue_zero <= r0;
    in_if.residue_one  <= r1;
    in_if.residue_two  <= r2;
    in_if.last_coeff   <= last;
    @(posedge clk_i);
    while (!(in_if.valid && in_if.ready)) begin
      @(posedge clk_i);
    end
    predict_coeff(r0, r1, r2, last, record);
    coeffs_sent++;
    if (last) begin
      products_sent++;
    end
    @(negedge clk_i);
  endtask

  function automatic logic [RES_W-1:0] rand62();
    return RES_W'({$urandom, $urandom});
  endfunction

  // Prime pick: mostly broad random values, sometimes zero, all ones or a small value.
  function automatic logic [RES_W-1:0] rand_prime();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RES_ONES;
      2:       return RES_W'($urandom_range(2, 1000));
      default: return rand62();
    endcase
  endfunction

  // Residue mostly in range for its prime, sometimes any 62-bit value.
  function automatic logic [RES_W-1:0] rand_residue(input logic [RES_W-1:0] p);
    if ($urandom_range(9) == 0) begin
      return rand62();
    end
    return RES_W'(64'(rand62()) % eff_prime(p));
  endfunction

  function automatic void add_cfg(input logic [IDX_W-1:0] idx, input logic [RES_W-1:0] data);
    row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_item(input logic [RES_W-1:0] r0, r1, r2, input bit last);
    row_t r;
    r      = '{default: '0};
    r.r0   = r0;
    r.r1   = r1;
    r.r2   = r2;
    r.last = last;
    directed_rows.push_back(r);
  endfunction

  // Item whose two limbs are written out by hand (reset settings, two limbs).
  function automatic void add_typed(input logic [RES_W-1:0] r0, r1, r2,
                                    input logic [LIMB_W-1:0] low, high);
    row_t r;
    r           = '{default: '0};
    r.r0        = r0;
    r.r1        = r1;
    r.r2        = r2;
    r.last      = 1'b1;
    r.typed     = 1'b1;
    r.low_limb  = low;
    r.last_limb = high;
    directed_rows.push_back(r);
  endfunction

  // Receiver ready, changed at the falling edge.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Limb checker and watchdog.
  always @(posedge clk_i) begin
    limb_t e;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_if.valid && out_if.ready) begin
        limbs_seen++;
        if (limb_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected limb %h", out_if.limb));
        end else begin
          e = limb_expect_q.pop_front();
          if (out_if.limb !== e.limb) begin
            report_mismatch($sformatf("limb %h, expected %h", out_if.limb, e.limb));
          end
          if (out_if.last_limb !== e.last_limb) begin
            report_mismatch($sformatf("last_limb %b, expected %b", out_if.last_limb,
                                      e.last_limb));
          end
          if (out_if.leftover_error !== e.leftover_error) begin
            report_mismatch($sformatf("leftover_error %b, expected %b",
                                      out_if.leftover_error, e.leftover_error));
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d limbs pending",
                 WATCHDOG_LIMIT, limb_expect_q.size());
        $display("crt3_carry_recompose_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [RES_W-1:0] r0, r1, r2;
    int               len;
    int               sent;
    row_t             row;

    errors         = 0;
    coeffs_sent    = 0;
    limbs_seen     = 0;
    products_sent  = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.residue_zero = '0;
    in_if.residue_one  = '0;
    in_if.residue_two  = '0;
    in_if.last_coeff   = 1'b0;
    out_if.ready       = 1'b1;

    // Predictor reset state matches the register defaults.
    prime0_q      = RES_W'(2);
    prime1_q      = RES_W'(2);
    prime2_q      = RES_W'(2);
    inv01_q       = '0;
    inv012_q      = '0;
    spacing_q     = CB_W'(32);
    limb_target_q = CNT_W'(2);
    window_q      = '0;
    offset_q      = '0;
    emitted_q     = '0;

    // Under reset settings the value is r0 mod 2, over two limbs.
    add_typed(RES_W'(5), RES_W'(7), RES_W'(9), 64'd1, 64'd0);
    add_typed(RES_ONES - 1, RES_ONES - 1, RES_ONES - 1, 64'd0, 64'd0);
    add_item(RES_ONES, RES_ONES, RES_ONES, 1'b0);
    add_item('0, '0, '0, 1'b1);
    // Zero prime, largest primes, wide spacing, limb count beyond the slots.
    add_cfg(REG_P0, '0);
    add_cfg(REG_P1, RES_ONES - 2);
    add_cfg(REG_P2, RES_ONES);
    add_cfg(REG_INV01, RES_ONES);
    add_cfg(REG_INV012, RES_W'(62'h2AAA_AAAA_AAAA_AAAB));
    add_cfg(REG_CB, RES_W'(127));
    add_cfg(REG_PL, RES_W'(25'h100_0000));
    add_item(RES_ONES, RES_ONES, RES_ONES, 1'b0);
    add_item(RES_ONES, RES_ONES - 1, RES_ONES, 1'b0);
    add_item(RES_ONES, RES_ONES, '0, 1'b1);
    // Zero spacing piles values up on one offset; zero limb count.
    add_cfg(REG_P0, RES_W'(62'h3FFF_FFFF_FFFF_FFC5));
    add_cfg(REG_CB, '0);
    add_cfg(REG_PL, '0);
    add_item(RES_ONES, RES_ONES, RES_ONES, 1'b0);
    add_item(RES_ONES, RES_ONES, RES_ONES, 1'b0);
    add_item(RES_ONES, RES_ONES, RES_ONES, 1'b1);
    // Full spacing with one limb asked: limbs leave early, overrun on drain.
    add_cfg(REG_CB, RES_W'(64));
    add_cfg(REG_PL, RES_W'(1));
    for (int i = 0; i < 5; i++) begin
      add_item(RES_ONES - RES_W'(i), rand62(), rand62(), 1'b0);
    end
    add_item(RES_W'(1), RES_W'(2), RES_W'(3), 1'b1);
    // Largest limb count, odd spacing near a limb.
    add_cfg(REG_CB, RES_W'(63));
    add_cfg(REG_PL, RES_W'(25'h1FF_FFFF));
    add_item(RES_ONES, '0, RES_ONES, 1'b0);
    add_item('0, RES_ONES, '0, 1'b1);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        in_if.valid <= 1'b0;
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_coeff(row.r0, row.r1, row.r2, row.last, !row.typed);
        if (row.typed) begin
          push_limb(row.low_limb, 1'b0, 1'b0, 1'b1);
          push_limb(row.last_limb, 1'b1, 1'b0, 1'b1);
        end
      end
    end
    in_if.valid <= 1'b0;

    // Random phases: new settings, then whole products of random length.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(REG_P0, rand_prime());
      write_reg(REG_P1, rand_prime());
      write_reg(REG_P2, rand_prime());
      write_reg(REG_INV01, rand62());
      write_reg(REG_INV012, rand62());
      write_reg(REG_CB, ($urandom_range(4) == 0) ? RES_W'($urandom_range(0, 127))
                                                  : RES_W'($urandom_range(1, 64)));
      case ($urandom_range(7))
        0:       write_reg(REG_PL, '0);
        1:       write_reg(REG_PL, rand62());
        default: write_reg(REG_PL, RES_W'($urandom_range(1, 5)));
      endcase
      case (ph % 4)
        1:       send_idle_pct = 54;
        2:       recv_stall_pct = 54;
        3: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
        default: ;
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          r0 = rand_residue(prime0_q);
          r1 = rand_residue(prime1_q);
          r2 = rand_residue(prime2_q);
          send_coeff(r0, r1, r2, (k == len - 1) || ($urandom_range(19) == 0), 1'b1);
          sent++;
        end
      end
      in_if.valid <= 1'b0;
    end

    wait_idle();
    $display("covered %0d coefficients in %0d products, %0d limbs checked",
             coeffs_sent, products_sent, limbs_seen);
    $display("directed table plus %0d random setting phases with idle and stall",
             RANDOM_PHASES);
    if (errors == 0) begin
      $display("crt3_carry_recompose_top regression: pass");
    end else begin
      $display("crt3_carry_recompose_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/crt3_pkg.sv
hw/rtl/crt3_if.sv
hw/rtl/crt3_datapath.sv
hw/rtl/crt3_controller.sv
hw/rtl/crt3_carry_recompose_top.sv
tb/sv/testbench.sv
